/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of the RTL core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMP(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NXT_ALWAYS(name, ck, ante, cons, msg) \
  name: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lsfh_pkg.sv */
// ----------------------------------------------------------------------------
// LIN slave frame handler package
// Word types, codes, sizes and small helper functions shared by the core.
// ----------------------------------------------------------------------------
package lsfh_pkg;

  // Table sizes.
  localparam int MSG_SLOTS = 16;
  localparam int MAX_DATA  = 8;
  localparam int SLOT_AW   = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
  localparam int TX_DEPTH  = MSG_SLOTS * MAX_DATA;
  localparam int TX_AW     = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int LEN_W     = 4;

  localparam logic [7:0] SYNC_FIELD = 8'h55;

  // Input operations.
  localparam logic [1:0] OP_BREAK    = 2'd0;
  localparam logic [1:0] OP_RX_BYTE  = 2'd1;
  localparam logic [1:0] OP_WR_SLOT  = 2'd2;
  localparam logic [1:0] OP_WR_TX    = 2'd3;

  // Slot roles.
  localparam logic [1:0] ROLE_UNUSED   = 2'd0;
  localparam logic [1:0] ROLE_LISTENER = 2'd1;
  localparam logic [1:0] ROLE_OWNER    = 2'd2;
  localparam logic [1:0] ROLE_RSVD     = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_TX_BYTE  = 3'd0;
  localparam logic [2:0] KIND_RX_DATA  = 3'd1;
  localparam logic [2:0] KIND_RX_OK    = 3'd2;
  localparam logic [2:0] KIND_TX_DONE  = 3'd3;
  localparam logic [2:0] KIND_SYNC_ERR = 3'd4;
  localparam logic [2:0] KIND_PAR_ERR  = 3'd5;
  localparam logic [2:0] KIND_CSUM_ERR = 3'd6;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [3:0] entry_index;
    logic [5:0] frame_id;
    logic [1:0] entry_role;
    logic [3:0] data_length;
    logic [2:0] byte_index;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] out_byte;
    logic [3:0] slot;
    logic       last;
  } out_item_t;

  // One message slot as stored in the slot table.
  typedef struct packed {
    logic [5:0]       id;
    logic [1:0]       role;
    logic [LEN_W-1:0] len;
  } slot_ent_t;

  // Eight-bit sum with end-around carry.
  function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'b0, s[8]};
  endfunction

  // P0 is even parity over ID bits 0,1,2,4; P1 is odd parity over bits 1,3,4,5.
  function automatic logic pid_parity_ok(input logic [7:0] pid);
    logic p0;
    logic p1;
    p0 = pid[0] ^ pid[1] ^ pid[2] ^ pid[4];
    p1 = ~(pid[1] ^ pid[3] ^ pid[4] ^ pid[5]);
    return (p0 == pid[6]) && (p1 == pid[7]);
  endfunction

endpackage

/* rtl/core/lin_slave_frame_handler.sv */
// ----------------------------------------------------------------------------
// LIN slave frame handler
// Slave side of a LIN frame: break, sync and PID checks, slot lookup,
// listener reception with checksum check and owner transmission.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                        Dir  Word
//   in        in_valid / in_ready / in_item  in   in_item_t (events, writes)
//   out       out_valid / out_ready / out_item out out_item_t (results)
//   cfg       cfg_we / cfg_wdata             in   checksum mode bit
//
// Break events and table writes leave the sequencer idle. A sync-error,
// PID-error or checksum byte goes through ST_EMIT; a data byte goes through
// ST_LEN first, because the slot length is reread from the slot table. A
// valid PID starts a search of the slot table, one entry per cycle from a
// memory with a registered read; an owner slot then streams its bytes from
// the transmit memory, each read in ST_TX_RD and sent in ST_TX_EMIT, then
// the checksum in ST_TX_DONE. Reset is synchronous and clears all slot
// valid bits, so no clearing pass is needed. With out_ready low the
// sequencer holds at its next result; new words are taken only when it is idle.
//
module lin_slave_frame_handler (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lsfh_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output lsfh_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  // Frame progress as seen on the bus.
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_BRK   = 6'b000010,
    PH_SYNC  = 6'b000100,
    PH_PID   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CHECK = 6'b100000
  } phase_t;

  // Sequencer that works one accepted word through the memories.
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SEARCH  = 7'b0000010,
    ST_LEN     = 7'b0000100,
    ST_EMIT    = 7'b0001000,
    ST_TX_RD   = 7'b0010000,
    ST_TX_EMIT = 7'b0100000,
    ST_TX_DONE = 7'b1000000
  } state_t;

  localparam logic [lsfh_pkg::SLOT_AW-1:0] LAST_SLOT =
    lsfh_pkg::SLOT_AW'(lsfh_pkg::MSG_SLOTS - 1);
  localparam logic [lsfh_pkg::LEN_W-1:0] MAX_LEN = lsfh_pkg::LEN_W'(lsfh_pkg::MAX_DATA);

  state_t                          state;
  phase_t                          frame_phase;
  logic                            checksum_mode;
  logic [lsfh_pkg::LEN_W-1:0]      byte_count;
  logic [7:0]                      running_sum;
  logic [lsfh_pkg::SLOT_AW-1:0]    active_slot;
  logic [7:0]                      rx_q;
  logic [lsfh_pkg::SLOT_AW-1:0]    srch_idx;
  logic [lsfh_pkg::SLOT_AW-1:0]    chk_idx;
  logic                            srch_primed;
  logic [lsfh_pkg::LEN_W-1:0]      tx_len;
  logic [lsfh_pkg::LEN_W-1:0]      tx_i;
  lsfh_pkg::out_item_t             pend;

  logic                            in_acc;
  logic                            out_free;
  logic                            out_load;
  lsfh_pkg::out_item_t             out_next;
  logic [3:0]                      slot_out;

  // Slot table ports.
  logic                            st_wr_en;
  lsfh_pkg::slot_ent_t             st_wr_data;
  logic                            st_rd_en;
  logic [lsfh_pkg::SLOT_AW-1:0]    st_rd_addr;
  lsfh_pkg::slot_ent_t             st_rd_data;

  // Transmit byte memory, MAX_DATA bytes per slot. Entries are undefined
  // until written, so it carries no valid bits.
  logic [7:0]                      tx_mem [lsfh_pkg::TX_DEPTH];
  logic                            tx_wr_en;
  logic [lsfh_pkg::TX_AW-1:0]      tx_wr_addr;
  logic                            tx_rd_en;
  logic [lsfh_pkg::TX_AW-1:0]      tx_rd_addr;
  logic [7:0]                      tx_rdata;

  logic                            slot_match;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;
  assign slot_out = 4'(active_slot);

  // Table writes happen only at acceptance, while the sequencer is idle, so
  // a write never overlaps a read of the same entry.
  assign st_wr_en = in_acc && (in_item.operation == lsfh_pkg::OP_WR_SLOT) &&
                    (int'(in_item.entry_index) < lsfh_pkg::MSG_SLOTS);
  assign st_wr_data.id   = in_item.frame_id;
  assign st_wr_data.role = (in_item.entry_role == lsfh_pkg::ROLE_RSVD) ?
                           lsfh_pkg::ROLE_UNUSED : in_item.entry_role;
  assign st_wr_data.len  = (in_item.data_length > MAX_LEN) ? MAX_LEN : in_item.data_length;

  assign tx_wr_en = in_acc && (in_item.operation == lsfh_pkg::OP_WR_TX) &&
                    (int'(in_item.entry_index) < lsfh_pkg::MSG_SLOTS) &&
                    (int'(in_item.byte_index) < lsfh_pkg::MAX_DATA);
  assign tx_wr_addr = lsfh_pkg::TX_AW'(int'(in_item.entry_index) * lsfh_pkg::MAX_DATA +
                                       int'(in_item.byte_index));
  assign tx_rd_addr = lsfh_pkg::TX_AW'(int'(active_slot) * lsfh_pkg::MAX_DATA + int'(tx_i));
  assign tx_rd_en   = (state == ST_TX_RD) && (tx_i != tx_len);

  // The search reads one entry per cycle; a data byte rereads its slot.
  always_comb begin
    st_rd_en   = 1'b0;
    st_rd_addr = srch_idx;
    if (state == ST_SEARCH) begin
      st_rd_en = 1'b1;
    end else if (in_acc && (in_item.operation == lsfh_pkg::OP_RX_BYTE) &&
                 (frame_phase == PH_DATA)) begin
      st_rd_en   = 1'b1;
      st_rd_addr = active_slot;
    end
  end

  assign slot_match = srch_primed && (st_rd_data.role != lsfh_pkg::ROLE_UNUSED) &&
                      (st_rd_data.id == rx_q[5:0]);

  lsfh_slot_table u_slot_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (st_wr_en),
    .wr_addr (lsfh_pkg::SLOT_AW'(in_item.entry_index)),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  always_ff @(posedge clk) begin
    if (tx_wr_en) begin
      tx_mem[tx_wr_addr] <= in_item.byte_value;
    end
    if (tx_rd_en) begin
      tx_rdata <= tx_mem[tx_rd_addr];
    end
  end

  // Output register: the sequencer loads a result only when the slot is free.
  always_comb begin
    out_load = 1'b0;
    out_next = pend;
    unique case (state)
      ST_EMIT: begin
        out_load = out_free;
      end
      ST_TX_EMIT: begin
        out_load = out_free;
        out_next = '{result_kind: lsfh_pkg::KIND_TX_BYTE, out_byte: tx_rdata,
                     slot: slot_out, last: 1'b0};
      end
      ST_TX_DONE: begin
        out_load = out_free;
        out_next = '{result_kind: lsfh_pkg::KIND_TX_DONE, out_byte: ~running_sum,
                     slot: slot_out, last: 1'b1};
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_mode <= 1'b0;
    end else if (cfg_we) begin
      checksum_mode <= cfg_wdata;
    end
  end

  // Main sequencer and frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frame_phase <= PH_IDLE;
      byte_count  <= '0;
      running_sum <= '0;
      active_slot <= '0;
      srch_idx    <= '0;
      chk_idx     <= '0;
      srch_primed <= 1'b0;
      tx_len      <= '0;
      tx_i        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (in_item.operation == lsfh_pkg::OP_BREAK)) begin
            frame_phase <= PH_BRK;
            byte_count  <= '0;
            running_sum <= '0;
          end else if (in_acc && (in_item.operation == lsfh_pkg::OP_RX_BYTE)) begin
            rx_q <= in_item.rx_byte;
            unique case (frame_phase)
              PH_IDLE: begin
                frame_phase <= PH_IDLE;
              end
              PH_BRK: begin
                // The break byte that follows a break event is skipped, whatever its value.
                frame_phase <= PH_SYNC;
              end
              PH_SYNC: begin
                if (in_item.rx_byte == lsfh_pkg::SYNC_FIELD) begin
                  frame_phase <= PH_PID;
                end else begin
                  frame_phase <= PH_IDLE;
                  pend  <= '{result_kind: lsfh_pkg::KIND_SYNC_ERR,
                             out_byte: in_item.rx_byte, slot: 4'd0, last: 1'b1};
                  state <= ST_EMIT;
                end
              end
              PH_PID: begin
                frame_phase <= PH_IDLE;
                if (!lsfh_pkg::pid_parity_ok(in_item.rx_byte)) begin
                  pend  <= '{result_kind: lsfh_pkg::KIND_PAR_ERR,
                             out_byte: in_item.rx_byte, slot: 4'd0, last: 1'b1};
                  state <= ST_EMIT;
                end else begin
                  srch_idx    <= '0;
                  srch_primed <= 1'b0;
                  state       <= ST_SEARCH;
                end
              end
              PH_DATA: begin
                running_sum <= lsfh_pkg::carry_add(running_sum, in_item.rx_byte);
                byte_count  <= byte_count + 1'b1;
                pend  <= '{result_kind: lsfh_pkg::KIND_RX_DATA,
                           out_byte: in_item.rx_byte, slot: slot_out, last: 1'b1};
                state <= ST_LEN;
              end
              PH_CHECK: begin
                frame_phase <= PH_IDLE;
                pend  <= '{result_kind: (~running_sum == in_item.rx_byte) ?
                                        lsfh_pkg::KIND_RX_OK : lsfh_pkg::KIND_CSUM_ERR,
                           out_byte: in_item.rx_byte, slot: slot_out, last: 1'b1};
                state <= ST_EMIT;
              end
              default: begin
                frame_phase <= PH_IDLE;
              end
            endcase
          end
        end

        ST_SEARCH: begin
          // Once primed, read data belongs to chk_idx, issued the cycle before.
          if (slot_match) begin
            active_slot <= chk_idx;
            running_sum <= checksum_mode ? rx_q : 8'h00;
            byte_count  <= '0;
            if (st_rd_data.role == lsfh_pkg::ROLE_LISTENER) begin
              frame_phase <= (st_rd_data.len != '0) ? PH_DATA : PH_CHECK;
              state       <= ST_IDLE;
            end else begin
              tx_len <= st_rd_data.len;
              tx_i   <= '0;
              state  <= ST_TX_RD;
            end
          end else if (srch_primed && (chk_idx == LAST_SLOT)) begin
            // No slot carries this identifier: the frame is ignored.
            state <= ST_IDLE;
          end else begin
            srch_primed <= 1'b1;
            chk_idx     <= srch_idx;
            if (srch_idx != LAST_SLOT) begin
              srch_idx <= srch_idx + 1'b1;
            end
          end
        end

        ST_LEN: begin
          // Slot length as it stands now; a rewrite during the frame counts.
          if ((byte_count >= st_rd_data.len) || (byte_count >= MAX_LEN)) begin
            frame_phase <= PH_CHECK;
          end
          state <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end

        ST_TX_RD: begin
          state <= (tx_i == tx_len) ? ST_TX_DONE : ST_TX_EMIT;
        end

        ST_TX_EMIT: begin
          if (out_free) begin
            running_sum <= lsfh_pkg::carry_add(running_sum, tx_rdata);
            tx_i        <= tx_i + 1'b1;
            state       <= ST_TX_RD;
          end
        end

        ST_TX_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/lsfh_slot_table.sv */
// ----------------------------------------------------------------------------
// Slot table
// Message slot memory with one write and one registered read port; a valid
// bit per entry makes unwritten slots read as unused.
// ----------------------------------------------------------------------------
module lsfh_slot_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [lsfh_pkg::SLOT_AW-1:0] wr_addr,
  input  lsfh_pkg::slot_ent_t         wr_data,
  input  logic                        rd_en,
  input  logic [lsfh_pkg::SLOT_AW-1:0] rd_addr,
  output lsfh_pkg::slot_ent_t         rd_data
);

  lsfh_pkg::slot_ent_t            mem [lsfh_pkg::MSG_SLOTS];
  logic [lsfh_pkg::MSG_SLOTS-1:0] vld;
  lsfh_pkg::slot_ent_t            rd_q;
  logic                           rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // An entry never written since reset reads as an all-zero, unused slot.
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

/* rtl/core/lsfh_checker.sv */
// ----------------------------------------------------------------------------
// LIN slave frame handler checker
// Port-level assertions on the frame handler, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsfh_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input lsfh_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input lsfh_pkg::out_item_t out_item
);

  // Reset leaves no result pending and the input open.
  `ASSERT_NXT_ALWAYS(a_reset_clean, clk, rst, !out_valid && in_ready, "reset did not clear the block")

  // A result that waits keeps its word.
  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")

  // Sync and parity errors end their word and belong to no slot.
  `ASSERT_IMP(a_hdr_err, clk, rst, out_valid && ((out_item.result_kind == lsfh_pkg::KIND_SYNC_ERR) || (out_item.result_kind == lsfh_pkg::KIND_PAR_ERR)), out_item.last && (out_item.slot == 4'd0), "header error result malformed")

  // A transmitted data byte never carries the last flag; the checksum result follows it.
  `ASSERT_IMP(a_tx_not_last, clk, rst, out_valid && (out_item.result_kind == lsfh_pkg::KIND_TX_BYTE), !out_item.last, "tx byte flagged as last")

  // A break word produces no result.
  `ASSERT_NXT(a_break_silent, clk, rst, in_valid && in_ready && (in_item.operation == lsfh_pkg::OP_BREAK) && !out_valid, !out_valid, "break produced a result")

endmodule

bind lin_slave_frame_handler lsfh_checker u_lsfh_checker (.*);

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// LIN slave frame handler testbench
// Drives break, byte and table-write words into the frame handler and checks
// every result word against a cycle-free model of the frame protocol, under
// random idling on both channels, a long receiver stall and both checksum
// modes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HALF_PERIOD    = 10;
  // Longest quiet spell of the block after its last result: a full slot
  // search plus a margin.
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int PHASE_WORDS    = 125;

  // Position of the model inside one frame.
  typedef enum logic [2:0] {
    FR_IDLE,
    FR_SKIP_BREAK,
    FR_SYNC,
    FR_PID,
    FR_DATA,
    FR_CHECK
  } frame_phase_t;

  // Ways in which a generated frame may deviate from a clean one.
  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SYNC,
    FRAME_BAD_PARITY,
    FRAME_BAD_CSUM,
    FRAME_CUT
  } frame_flavor_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid;
  logic                in_ready;
  lsfh_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  lsfh_pkg::out_item_t out_item;
  logic                cfg_we;
  logic                cfg_wdata;

  // Model state: frame position, checksum, the slot table and the transmit
  // byte store, together with a mark for every transmit byte written so far.
  frame_phase_t fr_phase = FR_IDLE;
  logic [3:0]   rx_count = '0;
  logic [7:0]   run_sum  = '0;
  int           active   = 0;
  logic         csum_mode = 1'b0;
  logic [5:0]   tbl_id   [lsfh_pkg::MSG_SLOTS];
  logic [1:0]   tbl_role [lsfh_pkg::MSG_SLOTS];
  logic [3:0]   tbl_len  [lsfh_pkg::MSG_SLOTS];
  logic [7:0]   tx_mem   [lsfh_pkg::TX_DEPTH];
  bit           tx_written [lsfh_pkg::TX_DEPTH];

  // Result words the model has predicted and the block has not yet delivered.
  lsfh_pkg::out_item_t results_due [$];

  int mismatches = 0;
  int words_sent = 0;

  // Traffic shaping shared by the sender and the receiver. While steady is
  // set neither side idles. A nonzero hold request makes the receiver drop
  // out_ready while it counts the request down in its own process.
  bit steady    = 1'b0;
  int hold_req  = 0;
  int hold_left = 0;

  lin_slave_frame_handler u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Model of the frame protocol
  // --------------------------------------------------------------------------

  // Eight-bit addition where the carry out wraps around into bit zero.
  function automatic logic [7:0] sum_carry(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 9'd255) s = s - 9'd255;
    return s[7:0];
  endfunction

  // Builds the protected identifier: P0 is even parity over ID bits 0, 1, 2
  // and 4, and P1 is the inverted parity over bits 1, 3, 4 and 5. A received
  // PID is good exactly when it equals the protected form of its own ID bits.
  function automatic logic [7:0] protect_id(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Lowest-numbered slot in use that carries the identifier, or -1.
  function automatic int find_slot(input logic [5:0] id);
    int hit;
    hit = -1;
    for (int s = lsfh_pkg::MSG_SLOTS - 1; s >= 0; s--)
      if (tbl_role[s] != lsfh_pkg::ROLE_UNUSED && tbl_id[s] == id) hit = s;
    return hit;
  endfunction

  function automatic lsfh_pkg::out_item_t make_result(input logic [2:0] kind,
                                                      input logic [7:0] val,
                                                      input int s);
    lsfh_pkg::out_item_t r;
    r.result_kind = kind;
    r.out_byte    = val;
    r.slot        = 4'(s);
    r.last        = 1'b0;
    return r;
  endfunction

  // Advances the model by one accepted word and queues the results it causes,
  // with the last flag on the final one.
  function automatic void predict_lin_word(input lsfh_pkg::in_item_t w);
    lsfh_pkg::out_item_t res [$];
    int                  hit;
    logic [7:0]          tx_val;
    case (w.operation)
      lsfh_pkg::OP_BREAK: begin
        // A break abandons whatever frame was running and re-arms.
        fr_phase = FR_SKIP_BREAK;
        rx_count = '0;
        run_sum  = '0;
      end
      lsfh_pkg::OP_WR_SLOT: begin
        tbl_id[w.entry_index]   = w.frame_id;
        tbl_role[w.entry_index] = (w.entry_role == lsfh_pkg::ROLE_RSVD) ?
                                  lsfh_pkg::ROLE_UNUSED : w.entry_role;
        tbl_len[w.entry_index]  = (w.data_length > lsfh_pkg::MAX_DATA) ?
                                  4'(lsfh_pkg::MAX_DATA) : w.data_length;
      end
      lsfh_pkg::OP_WR_TX: begin
        tx_mem[w.entry_index * lsfh_pkg::MAX_DATA + w.byte_index]     = w.byte_value;
        tx_written[w.entry_index * lsfh_pkg::MAX_DATA + w.byte_index] = 1'b1;
      end
      default: begin
        case (fr_phase)
          FR_SKIP_BREAK: fr_phase = FR_SYNC;
          FR_SYNC: begin
            if (w.rx_byte == lsfh_pkg::SYNC_FIELD) begin
              fr_phase = FR_PID;
            end else begin
              fr_phase = FR_IDLE;
              res.push_back(make_result(lsfh_pkg::KIND_SYNC_ERR, w.rx_byte, 0));
            end
          end
          FR_PID: begin
            fr_phase = FR_IDLE;
            if (w.rx_byte != protect_id(w.rx_byte[5:0])) begin
              res.push_back(make_result(lsfh_pkg::KIND_PAR_ERR, w.rx_byte, 0));
            end else begin
              hit = find_slot(w.rx_byte[5:0]);
              if (hit >= 0) begin
                active   = hit;
                run_sum  = csum_mode ? w.rx_byte : 8'h00;
                rx_count = '0;
                if (tbl_role[hit] == lsfh_pkg::ROLE_LISTENER) begin
                  fr_phase = (tbl_len[hit] != 0) ? FR_DATA : FR_CHECK;
                end else begin
                  for (int i = 0; i < tbl_len[hit]; i++) begin
                    tx_val  = tx_mem[hit * lsfh_pkg::MAX_DATA + i];
                    run_sum = sum_carry(run_sum, tx_val);
                    res.push_back(make_result(lsfh_pkg::KIND_TX_BYTE, tx_val, hit));
                  end
                  res.push_back(make_result(lsfh_pkg::KIND_TX_DONE, ~run_sum, hit));
                end
              end
            end
          end
          FR_DATA: begin
            // The slot length is reread here, so a table write during the
            // frame changes where the data ends.
            run_sum  = sum_carry(run_sum, w.rx_byte);
            rx_count = rx_count + 4'd1;
            res.push_back(make_result(lsfh_pkg::KIND_RX_DATA, w.rx_byte, active));
            if (rx_count >= tbl_len[active] || rx_count >= lsfh_pkg::MAX_DATA)
              fr_phase = FR_CHECK;
          end
          FR_CHECK: begin
            fr_phase = FR_IDLE;
            res.push_back(make_result((~run_sum == w.rx_byte) ? lsfh_pkg::KIND_RX_OK :
                                      lsfh_pkg::KIND_CSUM_ERR, w.rx_byte, active));
          end
          default: fr_phase = FR_IDLE;
        endcase
      end
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) results_due.push_back(res[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Word builders. Fields that the operation does not use carry random bits.
  // --------------------------------------------------------------------------

  function automatic lsfh_pkg::in_item_t rand_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return lsfh_pkg::in_item_t'(r[$bits(lsfh_pkg::in_item_t)-1:0]);
  endfunction

  function automatic lsfh_pkg::in_item_t break_word();
    lsfh_pkg::in_item_t w;
    w = rand_word();
    w.operation = lsfh_pkg::OP_BREAK;
    return w;
  endfunction

  function automatic lsfh_pkg::in_item_t rx_word(input logic [7:0] b);
    lsfh_pkg::in_item_t w;
    w = rand_word();
    w.operation = lsfh_pkg::OP_RX_BYTE;
    w.rx_byte   = b;
    return w;
  endfunction

  function automatic lsfh_pkg::in_item_t slot_word(input int idx, input logic [5:0] id,
                                                   input logic [1:0] role,
                                                   input logic [3:0] len);
    lsfh_pkg::in_item_t w;
    w = rand_word();
    w.operation   = lsfh_pkg::OP_WR_SLOT;
    w.entry_index = 4'(idx);
    w.frame_id    = id;
    w.entry_role  = role;
    w.data_length = len;
    return w;
  endfunction

  function automatic lsfh_pkg::in_item_t tx_word(input int idx, input int bi,
                                                 input logic [7:0] v);
    lsfh_pkg::in_item_t w;
    w = rand_word();
    w.operation   = lsfh_pkg::OP_WR_TX;
    w.entry_index = 4'(idx);
    w.byte_index  = 3'(bi);
    w.byte_value  = v;
    return w;
  endfunction

  // Mostly legal lengths, now and then one above the limit to hit saturation.
  function automatic lsfh_pkg::in_item_t random_slot_word();
    logic [3:0] len;
    len = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    return slot_word($urandom_range(lsfh_pkg::MSG_SLOTS - 1), 6'($urandom),
                     2'($urandom_range(3)), len);
  endfunction

  // Three times in four the identifier of some table entry, so that lookups
  // hit often; otherwise any identifier.
  function automatic logic [5:0] pick_id();
    if ($urandom_range(3) != 0) return tbl_id[$urandom_range(lsfh_pkg::MSG_SLOTS - 1)];
    return 6'($urandom);
  endfunction

  function automatic frame_flavor_t pick_flavor();
    int r;
    r = $urandom_range(99);
    if (r < 60) return FRAME_GOOD;
    if (r < 70) return FRAME_BAD_SYNC;
    if (r < 80) return FRAME_BAD_PARITY;
    if (r < 90) return FRAME_BAD_CSUM;
    return FRAME_CUT;
  endfunction

  // --------------------------------------------------------------------------
  // Input channel
  // --------------------------------------------------------------------------

  // Offers one word and waits for its handshake. The word is driven at a
  // falling edge and counts as accepted at the first rising edge with
  // in_ready high; valid stays high on return, so the next call either
  // replaces the word or lowers valid at the following falling edge.
  task automatic push_word(input lsfh_pkg::in_item_t w);
    if (!steady && $urandom_range(99) < 33) begin
      @(negedge clk) in_valid = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_item  = w;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_lin_word(w);
    words_sent++;
  endtask

  // Sends a word. When it is a PID that would start an owner frame, any
  // transmit byte of that slot that was never written is written first, so
  // the block is never asked to send undefined memory contents.
  task automatic send_word(input lsfh_pkg::in_item_t w);
    int hit;
    if (w.operation == lsfh_pkg::OP_RX_BYTE && fr_phase == FR_PID &&
        w.rx_byte == protect_id(w.rx_byte[5:0])) begin
      hit = find_slot(w.rx_byte[5:0]);
      if (hit >= 0 && tbl_role[hit] == lsfh_pkg::ROLE_OWNER)
        for (int i = 0; i < tbl_len[hit]; i++)
          if (!tx_written[hit * lsfh_pkg::MAX_DATA + i])
            push_word(tx_word(hit, i, 8'($urandom)));
    end
    push_word(w);
  endtask

  // One frame as a master would put it on the bus: break, break byte, sync,
  // PID and, for a listener slot, the data bytes and the checksum. The model
  // tells how many data bytes the addressed slot expects and what checksum
  // is correct.
  task automatic run_frame(input logic [5:0] id, input frame_flavor_t flavor);
    logic [7:0] pid;
    logic [7:0] bad_sync;
    int         cut_at;
    int         sent;
    pid    = protect_id(id);
    cut_at = $urandom_range(lsfh_pkg::MAX_DATA);
    sent   = 0;
    send_word(break_word());
    send_word(rx_word(8'($urandom)));
    if (flavor == FRAME_BAD_SYNC) begin
      do bad_sync = 8'($urandom); while (bad_sync == lsfh_pkg::SYNC_FIELD);
      send_word(rx_word(bad_sync));
      return;
    end
    send_word(rx_word(lsfh_pkg::SYNC_FIELD));
    if (flavor == FRAME_BAD_PARITY) pid = pid ^ {2'($urandom_range(3, 1)), 6'd0};
    send_word(rx_word(pid));
    while (fr_phase == FR_DATA) begin
      // A cut frame stops partway; the next frame's break must recover.
      if (flavor == FRAME_CUT && sent >= cut_at) return;
      // Now and then the table changes while the frame is under way.
      if ($urandom_range(99) < 4) send_word(random_slot_word());
      send_word(rx_word(8'($urandom)));
      sent++;
    end
    if (fr_phase == FR_CHECK && flavor != FRAME_CUT)
      send_word(rx_word((flavor == FRAME_BAD_CSUM) ? 8'($urandom) : ~run_sum));
  endtask

  // Lowers valid and waits until every predicted result has come out, then
  // lets the block finish any search that produces no result.
  task automatic wait_idle();
    @(negedge clk) in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called while the block is idle.
  task automatic set_checksum_mode(input logic m);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(posedge clk);
    csum_mode = m;
    @(negedge clk) cfg_we = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output channel
  // --------------------------------------------------------------------------

  // The receiver idles at random, stays ready throughout a steady stretch,
  // and honors a hold request by keeping out_ready low while it counts it down.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (steady) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(99) >= 33);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Every result word delivered is compared, field by field, with the oldest
  // prediction still due.
  always @(posedge clk) begin : check_results
    lsfh_pkg::out_item_t got;
    lsfh_pkg::out_item_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      got = out_item;
      if (results_due.size() == 0) begin
        report_mismatch("result word with nothing due", got, 0);
      end else begin
        want = results_due.pop_front();
        if (got.result_kind !== want.result_kind)
          report_mismatch("result_kind", got.result_kind, want.result_kind);
        if (got.out_byte !== want.out_byte)
          report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.slot !== want.slot)
          report_mismatch("slot", got.slot, want.slot);
        if (got.last !== want.last)
          report_mismatch("last", got.last, want.last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked words: a byte while idle, table writes at the extremes (last
  // slot, last byte position, reserved role, oversized length), then a bad
  // sync, a bad parity, an identifier with no slot in use, a listener frame
  // whose identifier also sits in a later owner slot, and an owner frame with
  // a saturated length.
  task automatic test_directed();
    send_word(rx_word(8'hFF));
    send_word(slot_word(0, 6'h3F, lsfh_pkg::ROLE_LISTENER, 4'd1));
    send_word(slot_word(1, 6'h3F, lsfh_pkg::ROLE_OWNER, 4'd2));
    send_word(slot_word(2, 6'h10, lsfh_pkg::ROLE_RSVD, 4'd3));
    send_word(slot_word(lsfh_pkg::MSG_SLOTS - 1, 6'h00, lsfh_pkg::ROLE_OWNER, 4'hF));
    send_word(tx_word(lsfh_pkg::MSG_SLOTS - 1, lsfh_pkg::MAX_DATA - 1, 8'hFF));
    send_word(tx_word(lsfh_pkg::MSG_SLOTS - 1, 0, 8'h00));
    run_frame(6'h2A, FRAME_BAD_SYNC);
    run_frame(6'h3F, FRAME_BAD_PARITY);
    run_frame(6'h10, FRAME_GOOD);
    run_frame(6'h3F, FRAME_BAD_CSUM);
    run_frame(6'h00, FRAME_GOOD);
    wait_idle();
  endtask

  // Mostly well-formed frames with random content, mixed with table writes
  // and fully random words, until the word count reaches the goal.
  task automatic random_traffic(input int word_goal);
    int r;
    while (words_sent < word_goal) begin
      r = $urandom_range(99);
      if (r < 70)
        run_frame(pick_id(), pick_flavor());
      else if (r < 80)
        send_word(random_slot_word());
      else if (r < 87)
        send_word(tx_word($urandom_range(lsfh_pkg::MSG_SLOTS - 1),
                          $urandom_range(lsfh_pkg::MAX_DATA - 1), 8'($urandom)));
      else
        send_word(rand_word());
    end
    wait_idle();
  endtask

  task automatic test_enhanced_checksum();
    set_checksum_mode(1'b1);
    random_traffic(words_sent + PHASE_WORDS);
  endtask

  task automatic test_classic_checksum();
    set_checksum_mode(1'b0);
    random_traffic(words_sent + PHASE_WORDS);
  endtask

  // Clean frames back to back with neither side idling.
  task automatic test_streaming();
    steady = 1'b1;
    repeat (15) run_frame(pick_id(), FRAME_GOOD);
    steady = 1'b0;
    wait_idle();
  endtask

  // Slot 0 becomes a full-length owner, so each frame yields nine results.
  // The receiver stalls for a long stretch while frames keep being offered,
  // which backs the block up until it refuses input; the sender then waits
  // for every result before going on.
  task automatic test_backpressure();
    send_word(slot_word(0, 6'h21, lsfh_pkg::ROLE_OWNER, 4'(lsfh_pkg::MAX_DATA)));
    hold_req = HOLD_CYCLES;
    repeat (6) run_frame(6'h21, FRAME_GOOD);
    wait_idle();
  endtask

  initial begin
    int waited;
    waited    = 0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    for (int s = 0; s < lsfh_pkg::MSG_SLOTS; s++) begin
      tbl_id[s]   = '0;
      tbl_role[s] = lsfh_pkg::ROLE_UNUSED;
      tbl_len[s]  = '0;
    end
    foreach (tx_mem[i]) begin
      tx_mem[i]     = '0;
      tx_written[i] = 1'b0;
    end
    repeat (5) @(negedge clk);
    rst = 1'b0;

    set_checksum_mode(1'b0);
    test_directed();
    test_enhanced_checksum();
    test_streaming();
    test_backpressure();
    test_classic_checksum();

    // All stimulus is in; give the block a bounded time to deliver the rest.
    @(negedge clk) in_valid = 1'b0;
    while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (results_due.size() != 0)
      report_mismatch("result words never delivered", results_due.size(), 0);
    if (mismatches == 0) begin
      $display("lin_slave_frame_handler regression: pass");
    end else begin
      $display("lin_slave_frame_handler regression: fail");
    end
    $finish;
  end

  // Watchdog for a block that hangs.
  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("lin_slave_frame_handler regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lsfh_pkg.sv
rtl/core/lsfh_slot_table.sv
rtl/core/lin_slave_frame_handler.sv
rtl/core/lsfh_checker.sv
test/testbench.sv
